[hdl/lr_pkg.sv]
// Shared types for the line rasterizer: walker states and queue status.
// No dependencies; used by lr_queue, lr_front and lr_back.
package lr_pkg;

	// Walker sequencer states
	typedef enum logic {
		WALK_IDLE,
		WALK_RUN
	} lr_walk_state_t;

	// Status that the segment queue reports to both sides
	typedef struct packed {
		logic can_push;
		logic has_data;
	} lr_qstat_t;

endpackage

[hdl/lr_queue.sv]
// Short register queue between the segment front end and the pixel walker.
// Depends on lr_pkg for the status struct.
module lr_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output lr_pkg::lr_qstat_t stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.can_push = (cnt_q != CW'(DEPTH));
	assign stat.has_data = (cnt_q != '0);
	assign do_push = push & stat.can_push;
	assign do_pop  = pop & stat.has_data;
	assign pop_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/lr_front.sv]
// Front end: accepts segments, picks the major axis and direction, and
// pushes a walk descriptor into the queue. Depends on lr_pkg.
module lr_front #(
	parameter int COORD_BITS = 6,
	parameter int DESC_BITS  = 5 * COORD_BITS + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  lr_pkg::lr_qstat_t     qstat,
	output logic                  push,
	output logic [DESC_BITS-1:0]  push_data
);
	logic [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
	logic                  hold_q;
	logic [COORD_BITS-1:0] adx, ady;
	logic [COORD_BITS-1:0] m0, n0, m1, n1;
	logic [COORD_BITS-1:0] dmaj, dmin;
	logic                  major_is_y;
	logic                  step_neg;

	assign push     = hold_q & qstat.can_push;
	assign in_ready = !hold_q | qstat.can_push;

	// Capture a segment on each input transaction
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x0_q <= start_x;
			y0_q <= start_y;
			x1_q <= end_x;
			y1_q <= end_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			hold_q <= 1'b1;
		end else if (push) begin
			hold_q <= 1'b0;
		end
	end

	// Classify: major axis, walk order and minor step direction
	always_comb begin
		adx = (x1_q >= x0_q) ? x1_q - x0_q : x0_q - x1_q;
		ady = (y1_q >= y0_q) ? y1_q - y0_q : y0_q - y1_q;
		major_is_y = !(ady < adx);
		if (!major_is_y) begin
			if (x0_q > x1_q) begin
				m0 = x1_q; n0 = y1_q; m1 = x0_q; n1 = y0_q;
			end else begin
				m0 = x0_q; n0 = y0_q; m1 = x1_q; n1 = y1_q;
			end
		end else begin
			if (y1_q > y0_q) begin
				m0 = y0_q; n0 = x0_q; m1 = y1_q; n1 = x1_q;
			end else begin
				m0 = y1_q; n0 = x1_q; m1 = y0_q; n1 = x0_q;
			end
		end
		dmaj     = m1 - m0;
		step_neg = (n1 < n0);
		dmin     = step_neg ? n0 - n1 : n1 - n0;
	end

	assign push_data = {major_is_y, step_neg, m0, n0, m1, dmaj, dmin};

endmodule

[hdl/lr_back.sv]
// Back end: pops walk descriptors, steps the Bresenham error term one pixel
// per cycle unless out_ready stalls, into a registered output; uses lr_pkg.
module lr_back #(
	parameter int COORD_BITS = 6,
	parameter int DESC_BITS  = 5 * COORD_BITS + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lr_pkg::lr_qstat_t     qstat,
	input  logic [DESC_BITS-1:0]  pop_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last_pixel
);
	localparam int DW = COORD_BITS + 3;

	lr_pkg::lr_walk_state_t state_q, state_nxt;

	logic                  major_is_y_q, step_neg_q;
	logic [COORD_BITS-1:0] m_q, n_q, m1_q;
	logic [DW-1:0]         dmaj2_q, dmin2_q;
	logic signed [DW-1:0]  d_q;
	logic                  out_valid_q, last_q;
	logic [COORD_BITS-1:0] px_q, py_q;

	logic                  d_major_is_y, d_step_neg;
	logic [COORD_BITS-1:0] d_m0, d_n0, d_m1, d_dmaj, d_dmin;
	logic                  advance;
	logic                  at_end;
	logic                  load;
	logic signed [DW-1:0]  d_adj;

	assign {d_major_is_y, d_step_neg, d_m0, d_n0, d_m1, d_dmaj, d_dmin} = pop_data;

	assign advance = (state_q == lr_pkg::WALK_RUN) && (!out_valid_q || out_ready);
	assign at_end  = (m_q == m1_q);

	// Sequence: pick up a descriptor when idle, run until the last pixel leaves
	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			lr_pkg::WALK_IDLE: begin
				if (qstat.has_data) begin
					pop       = 1'b1;
					load      = 1'b1;
					state_nxt = lr_pkg::WALK_RUN;
				end
			end
			lr_pkg::WALK_RUN: begin
				if (advance && at_end) begin
					state_nxt = lr_pkg::WALK_IDLE;
				end
			end
			default: state_nxt = lr_pkg::WALK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lr_pkg::WALK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Apply the minor step correction before adding the minor delta
	assign d_adj = (d_q > 0) ? d_q - $signed(dmaj2_q) : d_q;

	// Hold walk registers; load a descriptor or advance one pixel
	always_ff @(posedge clk) begin
		if (load) begin
			major_is_y_q <= d_major_is_y;
			step_neg_q   <= d_step_neg;
			m_q          <= d_m0;
			n_q          <= d_n0;
			m1_q         <= d_m1;
			dmaj2_q      <= {2'b00, d_dmaj, 1'b0};
			dmin2_q      <= {2'b00, d_dmin, 1'b0};
			d_q          <= $signed({2'b00, d_dmin, 1'b0}) - $signed({3'b000, d_dmaj});
		end else if (advance) begin
			m_q <= m_q + 1'b1;
			if (d_q > 0) begin
				n_q <= step_neg_q ? n_q - 1'b1 : n_q + 1'b1;
			end
			d_q <= d_adj + $signed(dmin2_q);
		end
	end

	// Drive the output register with the current pixel
	always_ff @(posedge clk) begin
		if (advance) begin
			px_q   <= major_is_y_q ? n_q : m_q;
			py_q   <= major_is_y_q ? m_q : n_q;
			last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign last_pixel = last_q;

endmodule

[hdl/line_rasterizer_top.sv]
// Channel   | direction | handshake            | payload
// segment   | in        | in_valid / in_ready  | start_x start_y end_x end_y
// pixel     | out       | out_valid / out_ready| pixel_x pixel_y last_pixel
//
// A segment yields max(|dx|,|dy|)+1 pixels, one per cycle from the walker's
// error-term update, plus an idle state in which it loads each new descriptor.
// The front end classifies a registered segment and queues it (two entries),
// so later segments are taken while the walker is still drawing.
// Reset (arst_n low) empties the queue and the walker; no pixel is pending.
// A stall on out_ready freezes the walker; the queue absorbs input meanwhile.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
module line_rasterizer_top #(
	parameter int COORD_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last_pixel
);
	localparam int DESC_BITS = 5 * COORD_BITS + 2;

	lr_pkg::lr_qstat_t    qstat;
	logic                 push, pop;
	logic [DESC_BITS-1:0] push_data, pop_data;

	// Classify segments
	lr_front #(
		.COORD_BITS(COORD_BITS),
		.DESC_BITS (DESC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.qstat    (qstat),
		.push     (push),
		.push_data(push_data)
	);

	// Buffer descriptors between the two sides
	lr_queue #(
		.WIDTH(DESC_BITS),
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (qstat)
	);

	// Walk pixels
	lr_back #(
		.COORD_BITS(COORD_BITS),
		.DESC_BITS (DESC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.last_pixel(last_pixel)
	);

endmodule

[bench/line_rasterizer_checker.sv]
// Pixel checker for line_rasterizer_top: traces every accepted segment with Bresenham
// stepping and compares each pixel transaction against the oldest traced pixel.
// Standalone module, no package dependency; instantiated beside the DUT by testbench.
module line_rasterizer_checker #(
	parameter int COORD_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic                  last_pixel,
	output int                    pixels_pending,
	output int                    mismatch_count
);

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  last;
	} pixel_t;

	// Pixels still owed by the DUT, oldest first
	pixel_t traced_pixels[$];

	// Print one line for the mismatch and count it
	task automatic report_mismatch(input string msg);
		$display("%0t: pixel mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Walk the segment along its major axis and queue every pixel it covers
	task automatic trace_segment(input int x0, input int y0, input int x1, input int y1);
		int     adx;
		int     ady;
		int     maj0;
		int     maj1;
		int     min0;
		int     min1;
		int     dmaj;
		int     dmin;
		int     dir;
		int     err;
		int     n;
		int     m;
		bit     major_y;
		pixel_t p;

		adx = (x1 > x0) ? x1 - x0 : x0 - x1;
		ady = (y1 > y0) ? y1 - y0 : y0 - y1;
		major_y = (ady >= adx);

		// Start from the endpoint with the smaller major coordinate
		if (!major_y) begin
			if (x0 > x1) begin
				maj0 = x1; min0 = y1; maj1 = x0; min1 = y0;
			end else begin
				maj0 = x0; min0 = y0; maj1 = x1; min1 = y1;
			end
		end else begin
			if (y1 > y0) begin
				maj0 = y0; min0 = x0; maj1 = y1; min1 = x1;
			end else begin
				maj0 = y1; min0 = x1; maj1 = y0; min1 = x0;
			end
		end

		dmaj = maj1 - maj0;
		dmin = min1 - min0;
		dir = 1;
		if (dmin < 0) begin
			dir = -1;
			dmin = -dmin;
		end
		err = 2 * dmin - dmaj;
		n = min0;

		for (m = maj0; m <= maj1; m++) begin
			p.x = major_y ? COORD_BITS'(n) : COORD_BITS'(m);
			p.y = major_y ? COORD_BITS'(m) : COORD_BITS'(n);
			p.last = (m == maj1);
			traced_pixels = {traced_pixels, p};
			// Step the minor axis once the error term goes positive
			if (err > 0) begin
				n += dir;
				err -= 2 * dmaj;
			end
			err += 2 * dmin;
		end
	endtask

	// Trace accepted segments, match pixel transactions in order
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;

		if (!arst_n) begin
			traced_pixels.delete();
			pixels_pending <= 0;
			mismatch_count = 0;
		end else begin
			if (in_valid && in_ready)
				trace_segment(start_x, start_y, end_x, end_y);
			if (out_valid && out_ready) begin
				if (traced_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected (%0d,%0d,last=%0b)",
						pixel_x, pixel_y, last_pixel));
				end else begin
					want = traced_pixels.pop_front();
					if (pixel_x !== want.x || pixel_y !== want.y || last_pixel !== want.last)
						report_mismatch($sformatf("got (%0d,%0d,last=%0b) want (%0d,%0d,last=%0b)",
							pixel_x, pixel_y, last_pixel, want.x, want.y, want.last));
				end
			end
			pixels_pending <= traced_pixels.size();
		end
	end

endmodule

[bench/testbench.sv]
// Top of the line_rasterizer_top bench: clock, reset, segment stimulus and pixel sink.
// Depends on line_rasterizer_top (and its package) and on line_rasterizer_checker.
module testbench;

	localparam int COORD_BITS      = 6;
	localparam int RANDOM_SEGMENTS = 256;
	localparam int QUIET_TAIL      = 60;
	localparam int DRAIN_POINT     = 120;
	localparam int HOLD_TRIGGER    = 40;
	localparam int LONG_HOLD       = 300;
	localparam int SETTLE_CYCLES   = 100;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic                  out_valid;
	logic                  out_ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  last_pixel;
	int                    pixels_pending;
	int                    mismatch_count;

	// Stimulus controls shared with the sink
	bit throttle = 1'b1;
	int segments_sent = 0;

	line_rasterizer_top #(
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.last_pixel(last_pixel)
	);

	line_rasterizer_checker #(
		.COORD_BITS(COORD_BITS)
	) pixel_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.last_pixel    (last_pixel),
		.pixels_pending(pixels_pending),
		.mismatch_count(mismatch_count)
	);

	// Clock: 10 time units
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one segment, optionally after a gap, and hold it until accepted
	task automatic send_segment(input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
		input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey);
		if (throttle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		do @(posedge clk); while (!in_ready);
		segments_sent++;
	endtask

	// Stop offering and wait until every traced pixel has come out
	task automatic drain_pixels();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0) @(posedge clk);
	endtask

	// Pixel sink: random stall bursts, one long hold-off to back up the input
	initial begin : pixel_sink
		bit held_long;

		held_long = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_long && segments_sent >= HOLD_TRIGGER) begin
				held_long = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (throttle && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Segment source and verdict
	initial begin : stimulus
		int                    k;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		start_x <= '0;
		start_y <= '0;
		end_x <= '0;
		end_y <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single points, full-length axes and diagonals, every octant
		send_segment(6'd0, 6'd0, 6'd0, 6'd0);
		send_segment(6'd63, 6'd63, 6'd63, 6'd63);
		send_segment(6'd0, 6'd17, 6'd63, 6'd17);
		send_segment(6'd63, 6'd40, 6'd0, 6'd40);
		send_segment(6'd9, 6'd0, 6'd9, 6'd63);
		send_segment(6'd50, 6'd63, 6'd50, 6'd0);
		send_segment(6'd0, 6'd0, 6'd63, 6'd63);
		send_segment(6'd63, 6'd63, 6'd0, 6'd0);
		send_segment(6'd63, 6'd0, 6'd0, 6'd63);
		send_segment(6'd0, 6'd63, 6'd63, 6'd0);
		send_segment(6'd3, 6'd5, 6'd40, 6'd20);
		send_segment(6'd40, 6'd20, 6'd3, 6'd5);
		send_segment(6'd2, 6'd30, 6'd60, 6'd12);
		send_segment(6'd60, 6'd12, 6'd2, 6'd30);
		send_segment(6'd10, 6'd1, 6'd25, 6'd55);
		send_segment(6'd25, 6'd55, 6'd10, 6'd1);
		send_segment(6'd44, 6'd4, 6'd20, 6'd62);
		send_segment(6'd20, 6'd62, 6'd44, 6'd4);
		send_segment(6'd30, 6'd30, 6'd31, 6'd30);
		send_segment(6'd30, 6'd30, 6'd30, 6'd29);
		send_segment(6'd30, 6'd30, 6'd31, 6'd31);
		send_segment(6'd30, 6'd30, 6'd29, 6'd31);
		send_segment(6'd0, 6'd0, 6'd63, 6'd1);
		send_segment(6'd0, 6'd62, 6'd1, 6'd0);

		// Random: mostly short segments, some long, some axis-aligned or diagonal
		for (k = 0; k < RANDOM_SEGMENTS; k++) begin
			throttle = (k < RANDOM_SEGMENTS - QUIET_TAIL) && ((k / 40) % 2 == 0);
			if (k == DRAIN_POINT)
				drain_pixels();
			sx = COORD_BITS'($urandom_range(0, 63));
			sy = COORD_BITS'($urandom_range(0, 63));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					ex = sx + COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
					ey = sy + COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
				end
				6, 7, 8: begin
					ex = COORD_BITS'($urandom_range(0, 63));
					ey = COORD_BITS'($urandom_range(0, 63));
				end
				default: begin
					ex = COORD_BITS'($urandom_range(0, 63));
					case ($urandom_range(0, 2))
						0: ey = sy;
						1: begin
							ey = COORD_BITS'($urandom_range(0, 63));
							ex = sx;
						end
						default: ey = (ex >= sx) ? sy + (ex - sx) : sy - (sx - ex);
					endcase
				end
			endcase
			send_segment(sx, sy, ex, ey);
		end

		// Let the last pixels out, then settle
		drain_pixels();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: end a hung run
	initial begin : watchdog
		#20000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
